// ===== hdl/pip_pkg.sv =====
// Package for the point-in-polygon block: opcodes, widths, request type.
// No dependencies.
package pip_pkg;
   localparam int MaxVertices = 256;
   localparam int AddrW = $clog2(MaxVertices);
   localparam int CountW = $clog2(MaxVertices + 1);
   localparam int CoordW = 32;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   // request as classified by the front end
   typedef struct packed {
      logic                     is_query;
      logic                     is_drop;
      logic [CountW-1:0]        count;
      logic signed [CoordW-1:0] px;
      logic signed [CoordW-1:0] py;
   } job_type;

   typedef struct packed {
      logic inside_res;
      logic is_answer;
      logic dropped;
   } result_type;
endpackage

// ===== hdl/pip_front.sv =====
// Front end: takes requests, handles appends/clears, queues jobs.
// Depends on pip_pkg. Vertex write port drives the back end memory.
module pip_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic signed [31:0]           req_coord_x,
   input  logic signed [31:0]           req_coord_y,
   output logic                         wr_en,
   output logic [pip_pkg::AddrW-1:0]    wr_addr,
   output logic [63:0]                  wr_data,
   output logic                         job_valid,
   input  logic                         job_ready,
   input  logic                         walk_busy,
   output pip_pkg::job_type             job
);
   import pip_pkg::*;

   logic [CountW-1:0] count_ff, count_in;
   job_type q_ff [2];
   logic    wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] fill_ff, fill_in;
   logic    acc, pop;
   logic    q_pend;
   job_type nj;

   // a query still waiting in the queue
   assign q_pend = (fill_ff != 2'd0 && q_ff[rp_ff].is_query) ||
                   (fill_ff == 2'd2 && q_ff[~rp_ff].is_query);

   // a request needs queue room; after a clear an append could overwrite a vertex
   // that a pending query still reads, so appends wait while a query is queued or walking
   assign req_ready = (fill_ff != 2'd2) &&
                      !(opcode_type'(req_opcode) == OP_APPEND && (q_pend || walk_busy));
   assign acc = req_valid && req_ready;
   assign job_valid = (fill_ff != 2'd0);
   assign job = q_ff[rp_ff];
   assign pop = job_valid && job_ready;

   always_comb begin
      count_in = count_ff;
      wr_en = 1'b0;
      wr_addr = count_ff[AddrW-1:0];
      wr_data = {req_coord_x, req_coord_y};
      nj.is_query = 1'b0;
      nj.is_drop = 1'b0;
      nj.count = count_ff;
      nj.px = req_coord_x;
      nj.py = req_coord_y;
      case (opcode_type'(req_opcode))
         OP_APPEND: begin
            if (count_ff < CountW'(MaxVertices)) begin
               wr_en = acc;
               if (acc) count_in = count_ff + 1'b1;
            end else begin
               nj.is_drop = 1'b1;
            end
         end
         OP_CLEAR: if (acc) count_in = '0;
         OP_QUERY: nj.is_query = 1'b1;
         default: ;
      endcase
      wp_in = acc ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      fill_in = fill_ff + {1'b0, acc} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (acc) q_ff[wp_ff] <= nj;
      if (reset) begin
         count_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         count_ff <= count_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         fill_ff <= fill_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_fill: assert property (@(posedge clock) disable iff (reset) fill_ff != 2'd3)
      else $error("queue overfill");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(MaxVertices)) else $error("count overflow");
   a_wr: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> count_ff == $past(count_ff) + 1'b1) else $error("append lost");
`endif
endmodule

// ===== hdl/pip_back.sv =====
// Back end: walks query edges via LOAD, MUL1, MUL2, DONE; one shared multiplier.
// Depends on pip_pkg. Holds the vertex memory.
module pip_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [pip_pkg::AddrW-1:0]    wr_addr,
   input  logic [63:0]                  wr_data,
   input  logic                         job_valid,
   output logic                         job_ready,
   input  pip_pkg::job_type             job,
   output logic                         walk_busy,
   output logic                         res_valid,
   input  logic                         res_ready,
   output pip_pkg::result_type          res
);
   import pip_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_FIRST, S_LOAD, S_MUL1, S_MUL2, S_DONE
   } state_type;

   logic [63:0] mem [MaxVertices];
   logic [63:0] rd_ff;
   logic [AddrW-1:0] raddr;

   state_type st_ff;
   logic [CountW-1:0] idx_ff, n_ff;
   logic signed [31:0] px_ff, py_ff, x0_ff, y0_ff, x1_ff, y1_ff;
   logic par_ff, brd_ff, out_v_ff;
   result_type out_ff;
   logic [63:0] lm_ff;
   logic ln_ff, cross_ff;
   logic signed [32:0] a_ff, b_ff, c_ff, d_ff;

   // current edge: (x1,y1) -> (x2,y2); x2 from memory or the first vertex
   logic signed [31:0] x2, y2;
   logic last;
   logic signed [32:0] dy, dx, ry, rx, ma, mb;
   logic [31:0] am, bm;
   logic [63:0] prod;
   logic pneg, left, brd;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[raddr];
   end

   assign last = (idx_ff == n_ff);
   assign x2 = last ? x0_ff : $signed(rd_ff[63:32]);
   assign y2 = last ? y0_ff : $signed(rd_ff[31:0]);
   assign dy = 33'(y2) - 33'(y1_ff);
   assign dx = 33'(x2) - 33'(x1_ff);
   assign ry = 33'(py_ff) - 33'(y1_ff);
   assign rx = 33'(px_ff) - 33'(x1_ff);

   // a*b in S_MUL2 (kept in lm_ff), c*d in S_DONE
   assign ma = (st_ff == S_MUL2) ? a_ff : c_ff;
   assign mb = (st_ff == S_MUL2) ? b_ff : d_ff;
   assign am = ma[32] ? 32'(-ma) : ma[31:0];
   assign bm = mb[32] ? 32'(-mb) : mb[31:0];
   assign prod = 64'(am) * 64'(bm);
   assign pneg = (prod != 0) && (ma[32] != mb[32]);
   assign left = (ln_ff != pneg) ? ln_ff : (ln_ff ? lm_ff > prod : lm_ff < prod);

   always_comb begin
      brd = ((px_ff == x1_ff) && (py_ff == y1_ff)) || ((px_ff == x2) && (py_ff == y2));
      if (y1_ff == py_ff && y2 == py_ff &&
          ((px_ff > x1_ff && px_ff < x2) || (px_ff > x2 && px_ff < x1_ff))) brd = 1'b1;
      if (x1_ff == px_ff && x2 == px_ff &&
          ((py_ff > y1_ff && py_ff < y2) || (py_ff > y2 && py_ff < y1_ff))) brd = 1'b1;
      raddr = idx_ff[AddrW-1:0];
      if (st_ff == S_IDLE) raddr = '0;
      else if (st_ff == S_MUL2 || st_ff == S_LOAD) raddr = idx_ff[AddrW-1:0];
   end

   assign job_ready = (st_ff == S_IDLE) && !out_v_ff;
   assign walk_busy = (st_ff != S_IDLE);
   assign res_valid = out_v_ff;
   assign res = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         if (out_v_ff && res_ready) out_v_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (job_valid && job_ready) begin
               px_ff <= job.px;
               py_ff <= job.py;
               n_ff <= job.count;
               par_ff <= 1'b0;
               brd_ff <= 1'b0;
               idx_ff <= CountW'(1);
               out_ff <= '{inside_res: 1'b0, is_answer: job.is_query, dropped: job.is_drop};
               if (job.is_query && job.count != '0) st_ff <= S_FIRST;
               else out_v_ff <= 1'b1;
            end
            S_FIRST: begin
               x0_ff <= $signed(rd_ff[63:32]);
               y0_ff <= $signed(rd_ff[31:0]);
               x1_ff <= $signed(rd_ff[63:32]);
               y1_ff <= $signed(rd_ff[31:0]);
               st_ff <= S_LOAD;
            end
            S_LOAD: begin
               // memory read of vertex idx in flight
               st_ff <= S_MUL1;
               x0_ff <= x0_ff;
            end
            S_MUL1: begin
               if (brd) brd_ff <= 1'b1;
               cross_ff <= (y1_ff > py_ff) != (y2 > py_ff);
               if (!dy[32]) begin
                  a_ff <= rx; b_ff <= dy; c_ff <= dx; d_ff <= ry;
               end else begin
                  a_ff <= dx; b_ff <= ry; c_ff <= rx; d_ff <= dy;
               end
               st_ff <= S_MUL2;
            end
            S_MUL2: begin
               lm_ff <= prod;
               ln_ff <= pneg;
               st_ff <= S_DONE;
            end
            S_DONE: begin
               if (cross_ff && left) par_ff <= ~par_ff;
               x1_ff <= x2;
               y1_ff <= y2;
               if (last) begin
                  out_ff.inside_res <= brd_ff | (par_ff ^ (cross_ff & left));
                  out_v_ff <= 1'b1;
                  st_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  st_ff <= S_LOAD;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_idx: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE && st_ff != S_FIRST |-> idx_ff <= n_ff) else $error("index past count");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !res_ready |=> out_v_ff && $stable(out_ff)) else $error("result lost");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != S_IDLE |-> !job_ready) else $error("job taken while busy");
`endif
endmodule

// ===== hdl/point_in_polygon_test.sv =====
// Top level of the point-in-polygon tester.
// Depends on pip_pkg, pip_front, pip_back.
//
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_opcode, req_coord_x, req_coord_y
// rsp      out  rsp_valid/rsp_ready    rsp_inside_res, rsp_is_answer, rsp_dropped
//
// Append, clear, unused and empty-polygon query requests: the result is set valid
// from idle, with no edge walk. Query: each edge, closing edge included, takes the per-edge
// sequence around the one shared 32x32 multiplier (memory read, two products, compare).
// Reset is synchronous, active high; it empties the polygon and the queue.
// A two-entry request queue lets requests arrive while a query walks edges; appends
// stall while any query is queued or walking, and a held result stalls the back end.
module point_in_polygon_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_inside_res,
   output logic               rsp_is_answer,
   output logic               rsp_dropped
);
   import pip_pkg::*;

   logic wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [63:0] wr_data;
   logic job_valid, job_ready;
   logic walk_busy;
   job_type job;
   result_type res;

   // appends write memory at acceptance; queued queries see all earlier vertices
   pip_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_opcode, .req_coord_x,
      .req_coord_y, .wr_en, .wr_addr, .wr_data, .job_valid, .job_ready, .walk_busy, .job
   );

   pip_back u_back (
      .clock, .reset, .wr_en, .wr_addr, .wr_data, .job_valid, .job_ready, .job,
      .walk_busy, .res_valid(rsp_valid), .res_ready(rsp_ready), .res
   );

   assign rsp_inside_res = res.inside_res;
   assign rsp_is_answer = res.is_answer;
   assign rsp_dropped = res.dropped;
endmodule
